### hdl/pvclk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvclk_pkg
// Shared types and constants of the paravirtual clock and tick statistics
// block: word formats, configuration set, op codes, divider constants.
// ----------------------------------------------------------------------------
package pvclk_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CYCLE_BASE       = 3'd0,
        REG_SYSTEM_TIME_BASE = 3'd1,
        REG_SCALE_FRACTION   = 3'd2,
        REG_SCALE_SHIFT      = 3'd3,
        REG_WALL_SECONDS     = 3'd4,
        REG_WALL_NANOS       = 3'd5,
        REG_TICK_PERIOD      = 3'd6
    } t_reg_idx;

    // op codes carried by an input word; the spare code reads the time
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_EVENT = 2'd1,
        OP_ARM   = 2'd2
    } t_op;

    // pipeline stage positions, input register first
    localparam int NUM_STAGES = 8;
    localparam int STG_IN     = 0;
    localparam int STG_SHIFT  = 1;
    localparam int STG_MUL    = 2;
    localparam int STG_NOW    = 3;
    localparam int STG_PART   = 4;
    localparam int STG_QUOT   = 5;
    localparam int STG_REM    = 6;
    localparam int STG_OUT    = 7;

    typedef logic [NUM_STAGES-1:0] t_stage_vec;

    // reset values
    localparam logic [31:0] TICK_PERIOD_RST = 32'd1000000;
    localparam logic [63:0] STAT_INIT       = 64'h0000_0000_ffff_ffff;

    // divide by 1e9: drop 9 low bits, then divide by 5^9 through a reciprocal
    // M = ceil(2^76 / 5^9), exact for the 55-bit shifted value
    localparam int           NS_DROP    = 9;
    localparam logic [20:0]  DIV_D      = 21'd1953125;
    localparam logic [55:0]  DIV_M      = 56'd38685626227668134;
    localparam logic [27:0]  DIV_M_HI   = DIV_M[55:28];
    localparam logic [27:0]  DIV_M_LO   = DIV_M[27:0];
    localparam int           DIV_SHIFT  = 76;

    // divide remainder by 1000: drop 3 low bits, then multiply by
    // ceil(2^34 / 125), exact for a 27-bit value
    localparam logic [27:0]  USEC_M     = 28'd137438954;
    localparam int           USEC_SHIFT = 34;

    // configuration set
    typedef struct packed {
        logic [63:0] cycle_base;
        logic [63:0] system_time_base;
        logic [31:0] scale_fraction;
        logic [5:0]  scale_shift;
        logic [31:0] wall_seconds_base;
        logic [29:0] wall_nanos_base;
        logic [31:0] tick_period;
    } t_cfg;

    // input word
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] cycle_now;
    } t_in_word;

    // timer statistics as seen after one word
    typedef struct packed {
        logic [63:0]        next_deadline;
        logic [63:0]        tick_total;
        logic [62:0]        latency_min;
        logic [62:0]        latency_max;
        logic signed [63:0] interval_min;
        logic signed [63:0] interval_max;
    } t_stats;

    // result word
    typedef struct packed {
        logic [63:0]        time_ns;
        logic [39:0]        wall_sec;
        logic [19:0]        wall_usec;
        logic [63:0]        next_deadline;
        logic [63:0]        tick_total;
        logic [62:0]        latency_min;
        logic [62:0]        latency_max;
        logic signed [63:0] interval_min;
        logic signed [63:0] interval_max;
    } t_out_word;

endpackage
`default_nettype wire

### hdl/pvclk_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvclk_scale
// Cycle counter to nanoseconds: input register, delta and pre-shift,
// two 32x32 fraction products, base add. Four register stages.
// ----------------------------------------------------------------------------
module pvclk_scale
    import pvclk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_vec  i_load,
    input  wire t_in_word    i_in_word,
    input  wire t_cfg        i_cfg,
    output logic [1:0]       o_op,
    output logic [63:0]      o_now
);

    t_in_word    r_in;
    logic [1:0]  r_s1_op;
    logic [63:0] r_s1_delta;
    logic [1:0]  r_s2_op;
    logic [63:0] r_s2_lo;
    logic [63:0] r_s2_hi;
    logic [1:0]  r_s3_op;
    logic [63:0] r_s3_now;

    logic [63:0] w_delta;
    logic [5:0]  w_right;
    logic [63:0] w_shifted;
    logic [63:0] w_lo;
    logic [63:0] w_hi;
    logic [63:0] w_now;

    // delta and signed pre-shift; negative codes shift right by 1..32
    always_comb begin
        w_delta = r_in.cycle_now - i_cfg.cycle_base;
        w_right = 6'(7'd64 - {1'b0, i_cfg.scale_shift});
        if (i_cfg.scale_shift[5]) begin
            w_shifted = w_delta >> w_right;
        end else begin
            w_shifted = w_delta << i_cfg.scale_shift[4:0];
        end
    end

    // fraction products of both halves
    assign w_lo = 64'(r_s1_delta[31:0])  * 64'(i_cfg.scale_fraction);
    assign w_hi = 64'(r_s1_delta[63:32]) * 64'(i_cfg.scale_fraction);

    // product bits 32 and up plus base time
    assign w_now = i_cfg.system_time_base + r_s2_hi + {32'd0, r_s2_lo[63:32]};

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_load[STG_IN]) begin
            r_in <= i_in_word;
        end
        if (i_load[STG_SHIFT]) begin
            r_s1_op    <= r_in.op;
            r_s1_delta <= w_shifted;
        end
        if (i_load[STG_MUL]) begin
            r_s2_op <= r_s1_op;
            r_s2_lo <= w_lo;
            r_s2_hi <= w_hi;
        end
        if (i_load[STG_NOW]) begin
            r_s3_op  <= r_s2_op;
            r_s3_now <= w_now;
        end
    end

    assign o_op  = r_s3_op;
    assign o_now = r_s3_now;

endmodule
`default_nettype wire

### hdl/pvclk_wall.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvclk_wall
// Wall clock split: adds the nanoseconds base, divides by 1e9 through a
// reciprocal in partial products, forms the remainder and microseconds.
// ----------------------------------------------------------------------------
module pvclk_wall
    import pvclk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_stage_vec  i_load,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_now,
    input  wire t_cfg        i_cfg,
    output logic [1:0]       o_op,
    output logic [63:0]      o_now,
    output logic [39:0]      o_sec,
    output logic [19:0]      o_usec
);

    logic [1:0]   r_s4_op;
    logic [63:0]  r_s4_now;
    logic [8:0]   r_s4_lo9;
    logic [20:0]  r_s4_y_lo;
    logic [54:0]  r_s4_pp_hh;
    logic [54:0]  r_s4_pp_hl;
    logic [55:0]  r_s4_pp_lh;
    logic [55:0]  r_s4_pp_ll;
    logic [1:0]   r_s5_op;
    logic [63:0]  r_s5_now;
    logic [8:0]   r_s5_lo9;
    logic [20:0]  r_s5_y_lo;
    logic [34:0]  r_s5_q;
    logic [1:0]   r_s6_op;
    logic [63:0]  r_s6_now;
    logic [34:0]  r_s6_q;
    logic [26:0]  r_s6_z;

    logic [63:0]  w_wall_ns;
    logic [54:0]  w_y;
    logic [110:0] w_prod;
    logic [20:0]  w_qd;
    logic [20:0]  w_rem_y;
    logic [54:0]  w_usec_prod;

    // wall nanoseconds with the low 9 bits set aside
    assign w_wall_ns = i_now + 64'(i_cfg.wall_nanos_base);
    assign w_y       = w_wall_ns[63:NS_DROP];

    // reciprocal product, sum of the four partial products
    assign w_prod = {r_s4_pp_hh, 56'd0}
                  + {28'd0, r_s4_pp_hl, 28'd0}
                  + {27'd0, r_s4_pp_lh, 28'd0}
                  + {55'd0, r_s4_pp_ll};

    // remainder of the shifted value, only its low 21 bits matter
    assign w_qd    = r_s5_q[20:0] * DIV_D;
    assign w_rem_y = r_s5_y_lo - w_qd;

    // microseconds from the remainder over 8
    assign w_usec_prod = 55'(r_s6_z) * 55'(USEC_M);
    assign o_usec      = w_usec_prod[USEC_SHIFT +: 20];
    assign o_sec       = 40'(i_cfg.wall_seconds_base) + 40'(r_s6_q);

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_load[STG_PART]) begin
            r_s4_op    <= i_op;
            r_s4_now   <= i_now;
            r_s4_lo9   <= w_wall_ns[NS_DROP-1:0];
            r_s4_y_lo  <= w_y[20:0];
            r_s4_pp_hh <= 55'(w_y[54:28]) * 55'(DIV_M_HI);
            r_s4_pp_hl <= 55'(w_y[54:28]) * 55'(DIV_M_LO);
            r_s4_pp_lh <= 56'(w_y[27:0])  * 56'(DIV_M_HI);
            r_s4_pp_ll <= 56'(w_y[27:0])  * 56'(DIV_M_LO);
        end
        if (i_load[STG_QUOT]) begin
            r_s5_op   <= r_s4_op;
            r_s5_now  <= r_s4_now;
            r_s5_lo9  <= r_s4_lo9;
            r_s5_y_lo <= r_s4_y_lo;
            r_s5_q    <= w_prod[110:DIV_SHIFT];
        end
        if (i_load[STG_REM]) begin
            r_s6_op  <= r_s5_op;
            r_s6_now <= r_s5_now;
            r_s6_q   <= r_s5_q;
            r_s6_z   <= {w_rem_y, r_s5_lo9[8:3]};
        end
    end

    assign o_op  = r_s6_op;
    assign o_now = r_s6_now;

endmodule
`default_nettype wire

### hdl/pvclk_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvclk_stats
// Timer state: periodic deadline, tick count, latency and interval extremes.
// Next values are shown combinationally and taken on each update.
// ----------------------------------------------------------------------------
module pvclk_stats
    import pvclk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_upd,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_now,
    input  wire logic [31:0] i_period,
    output t_stats           o_stats
);

    logic [63:0]        r_deadline;
    logic [63:0]        r_last;
    logic [63:0]        r_tick;
    logic [62:0]        r_lat_min;
    logic [62:0]        r_lat_max;
    logic signed [63:0] r_int_min;
    logic signed [63:0] r_int_max;

    logic [63:0]        n_deadline;
    logic [63:0]        n_last;
    logic [63:0]        n_tick;
    logic [62:0]        n_lat_min;
    logic [62:0]        n_lat_max;
    logic signed [63:0] n_int_min;
    logic signed [63:0] n_int_max;

    logic [63:0]        w_latency;
    logic signed [63:0] w_interval;
    logic               w_late;

    // op decode and extreme tracking
    always_comb begin
        n_deadline = r_deadline;
        n_last     = r_last;
        n_tick     = r_tick;
        n_lat_min  = r_lat_min;
        n_lat_max  = r_lat_max;
        n_int_min  = r_int_min;
        n_int_max  = r_int_max;
        w_latency  = i_now - r_deadline;
        w_interval = $signed(i_now - r_last);
        // late means a strictly positive signed latency
        w_late     = !w_latency[63] && (w_latency != '0);
        unique case (i_op)
            OP_ARM: begin
                n_deadline = i_now + 64'(i_period);
                n_last     = i_now;
            end
            OP_EVENT: begin
                n_tick = r_tick + 64'd1;
                if (w_late) begin
                    if (w_latency[62:0] > r_lat_max) begin
                        n_lat_max = w_latency[62:0];
                    end
                    if (w_latency[62:0] < r_lat_min) begin
                        n_lat_min = w_latency[62:0];
                    end
                    if (w_interval > r_int_max) begin
                        n_int_max = w_interval;
                    end
                    if (w_interval < r_int_min) begin
                        n_int_min = w_interval;
                    end
                    n_last = i_now;
                end
                n_deadline = r_deadline + 64'(i_period);
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_last     <= '0;
            r_tick     <= '0;
            r_lat_min  <= STAT_INIT[62:0];
            r_lat_max  <= '0;
            r_int_min  <= $signed(STAT_INIT);
            r_int_max  <= '0;
        end else if (i_upd) begin
            r_deadline <= n_deadline;
            r_last     <= n_last;
            r_tick     <= n_tick;
            r_lat_min  <= n_lat_min;
            r_lat_max  <= n_lat_max;
            r_int_min  <= n_int_min;
            r_int_max  <= n_int_max;
        end
    end

    // statistics after the word now being finished
    always_comb begin
        o_stats.next_deadline = n_deadline;
        o_stats.tick_total    = n_tick;
        o_stats.latency_min   = n_lat_min;
        o_stats.latency_max   = n_lat_max;
        o_stats.interval_min  = n_int_min;
        o_stats.interval_max  = n_int_max;
    end

`ifndef ASSERT_OFF
    // largest latency never shrinks between resets
    a_lat_max_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |=> r_lat_max >= $past(r_lat_max))
        else $error("latency maximum decreased");

    // smallest latency starts at the init value and only drops
    a_lat_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd |=> r_lat_min <= STAT_INIT[62:0] && r_lat_min <= $past(r_lat_min))
        else $error("latency minimum above its bound or increased");

    // a timer event counts exactly one tick
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_upd && i_op == OP_EVENT |=> r_tick == $past(r_tick) + 64'd1)
        else $error("tick count not advanced by one on an event");
`endif

endmodule
`default_nettype wire

### hdl/paravirt_clock_and_tick_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paravirt_clock_and_tick_stats
// Top level: configuration registers, pipeline flow control, result register.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle when the output side does not stall. Every
// stage has its own valid bit and a load enable that ripples back from the
// result register, so bubbles close up and a new word is taken while a
// finished result still waits. The timer statistics close their loop inside
// the last stage, which lets events follow each other in consecutive cycles.
// Configuration is written through a plain write port and must only change
// while no word is in flight.
module paravirt_clock_and_tick_stats
    import pvclk_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_stage_vec  r_valid;
    t_stage_vec  n_valid;
    t_stage_vec  w_load;
    t_out_word   r_out;

    logic        w_upd;
    logic [1:0]  w_s3_op;
    logic [63:0] w_s3_now;
    logic [1:0]  w_s6_op;
    logic [63:0] w_s6_now;
    logic [39:0] w_sec;
    logic [19:0] w_usec;
    t_stats      w_stats;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_base        <= '0;
            r_cfg.system_time_base  <= '0;
            r_cfg.scale_fraction    <= '0;
            r_cfg.scale_shift       <= '0;
            r_cfg.wall_seconds_base <= '0;
            r_cfg.wall_nanos_base   <= '0;
            r_cfg.tick_period       <= TICK_PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CYCLE_BASE:       r_cfg.cycle_base        <= i_cfg_data;
                REG_SYSTEM_TIME_BASE: r_cfg.system_time_base  <= i_cfg_data;
                REG_SCALE_FRACTION:   r_cfg.scale_fraction    <= i_cfg_data[31:0];
                REG_SCALE_SHIFT:      r_cfg.scale_shift       <= i_cfg_data[5:0];
                REG_WALL_SECONDS:     r_cfg.wall_seconds_base <= i_cfg_data[31:0];
                REG_WALL_NANOS:       r_cfg.wall_nanos_base   <= i_cfg_data[29:0];
                REG_TICK_PERIOD:      r_cfg.tick_period       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // load enables ripple back from the result register
    always_comb begin
        w_load[STG_OUT] = !r_valid[STG_OUT] || !i_out_stall;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
        n_valid[STG_IN] = w_load[STG_IN] ? i_in_valid : r_valid[STG_IN];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = w_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_stall = !w_load[STG_IN];
    assign w_upd      = w_load[STG_OUT] && r_valid[STG_REM];

    // time base scaling
    pvclk_scale u_scale (
        .i_clk     (i_clk),
        .i_load    (w_load),
        .i_in_word (i_in_word),
        .i_cfg     (r_cfg),
        .o_op      (w_s3_op),
        .o_now     (w_s3_now)
    );

    // wall clock split
    pvclk_wall u_wall (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_op   (w_s3_op),
        .i_now  (w_s3_now),
        .i_cfg  (r_cfg),
        .o_op   (w_s6_op),
        .o_now  (w_s6_now),
        .o_sec  (w_sec),
        .o_usec (w_usec)
    );

    // timer statistics
    pvclk_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_upd),
        .i_op     (w_s6_op),
        .i_now    (w_s6_now),
        .i_period (r_cfg.tick_period),
        .o_stats  (w_stats)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load[STG_OUT]) begin
            r_out.time_ns       <= w_s6_now;
            r_out.wall_sec      <= w_sec;
            r_out.wall_usec     <= w_usec;
            r_out.next_deadline <= w_stats.next_deadline;
            r_out.tick_total    <= w_stats.tick_total;
            r_out.latency_min   <= w_stats.latency_min;
            r_out.latency_max   <= w_stats.latency_max;
            r_out.interval_min  <= w_stats.interval_min;
            r_out.interval_max  <= w_stats.interval_max;
        end
    end

    assign o_out_valid = r_valid[STG_OUT];
    assign o_out_word  = r_out;

`ifndef ASSERT_OFF
    // with the result register empty the input side is never held off
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[STG_OUT] |-> !o_in_stall)
        else $error("input stalled while result register empty");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for paravirt_clock_and_tick_stats: a queue-fed driver
// offers cycle counter words, a shadow model predicts nanoseconds, wall clock
// and tick statistics per accepted word, and a monitor compares every result
// field by field under random idle gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;
    import pvclk_pkg::*;

    localparam int          CLK_HALF   = 4;
    localparam int          RST_CYCLES = 7;
    localparam int          LONG_HOLD  = 200;
    localparam int          DRAIN_WAIT = 20;
    localparam longint      TIMEOUT_NS = 5_000_000;
    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;
    localparam logic [63:0] NS_PER_US  = 64'd1000;
    localparam logic [1:0]  OP_SPARE   = 2'd3;

    // clock, reset and block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and scoreboard storage
    t_in_word  pending_words[$];
    t_out_word expected_readings[$];
    int        mismatches = 0;

    // idling controls; the stimulus sets switches and requests at the falling edge
    bit gaps_on       = 1'b1;
    bit stall_on      = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int gap_left      = 0;
    int stall_left    = 0;

    // shadow of the configuration and of the timer state
    t_cfg        cfg_shadow = '{64'd0, 64'd0, 32'd0, 6'd0, 32'd0, 30'd0, TICK_PERIOD_RST};
    logic [63:0] deadline_ns   = '0;
    logic [63:0] last_late_ns  = '0;
    logic [63:0] tick_count    = '0;
    logic [63:0] lat_lo        = STAT_INIT;
    logic [63:0] lat_hi        = '0;
    logic [63:0] interval_lo   = STAT_INIT;
    logic [63:0] interval_hi   = '0;

    paravirt_clock_and_tick_stats u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // idle run length: mostly short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // counter value to nanoseconds since boot
    function automatic logic [63:0] cycles_to_ns(logic [63:0] cyc);
        logic [63:0] delta;
        logic [95:0] prod;
        delta = cyc - cfg_shadow.cycle_base;
        if (cfg_shadow.scale_shift[5]) begin
            delta = delta >> (64 - int'(cfg_shadow.scale_shift));
        end else begin
            delta = delta << cfg_shadow.scale_shift[4:0];
        end
        prod = {32'd0, delta} * {64'd0, cfg_shadow.scale_fraction};
        return cfg_shadow.system_time_base + prod[95:32];
    endfunction

    // timer state update and result fields for one word
    function automatic t_out_word predict_reading(t_in_word w);
        t_out_word   r;
        logic [63:0] now;
        logic [63:0] wall_ns;
        logic [63:0] lateness;
        logic [63:0] interval;
        now     = cycles_to_ns(w.cycle_now);
        wall_ns = now + 64'(cfg_shadow.wall_nanos_base);
        case (w.op)
            OP_ARM: begin
                deadline_ns  = now + 64'(cfg_shadow.tick_period);
                last_late_ns = now;
            end
            OP_EVENT: begin
                lateness   = now - deadline_ns;
                tick_count = tick_count + 64'd1;
                // only late events feed the extremes
                if ($signed(lateness) > 0) begin
                    interval = now - last_late_ns;
                    if ($signed(lateness) > $signed(lat_hi)) lat_hi = lateness;
                    if ($signed(lateness) < $signed(lat_lo)) lat_lo = lateness;
                    if ($signed(interval) > $signed(interval_hi)) interval_hi = interval;
                    if ($signed(interval) < $signed(interval_lo)) interval_lo = interval;
                    last_late_ns = now;
                end
                deadline_ns = deadline_ns + 64'(cfg_shadow.tick_period);
            end
            default: begin
            end
        endcase
        r.time_ns       = now;
        r.wall_sec      = 40'(64'(cfg_shadow.wall_seconds_base) + wall_ns / NS_PER_SEC);
        r.wall_usec     = 20'((wall_ns % NS_PER_SEC) / NS_PER_US);
        r.next_deadline = deadline_ns;
        r.tick_total    = tick_count;
        r.latency_min   = lat_lo[62:0];
        r.latency_max   = lat_hi[62:0];
        r.interval_min  = interval_lo;
        r.interval_max  = interval_hi;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    task automatic check_reading(input t_out_word got);
        t_out_word want;
        if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result word with nothing expected: %h", got);
            return;
        end
        want = expected_readings.pop_front();
        cmp_field("time_ns",       want.time_ns,       got.time_ns);
        cmp_field("wall_sec",      want.wall_sec,      got.wall_sec);
        cmp_field("wall_usec",     want.wall_usec,     got.wall_usec);
        cmp_field("next_deadline", want.next_deadline, got.next_deadline);
        cmp_field("tick_total",    want.tick_total,    got.tick_total);
        cmp_field("latency_min",   want.latency_min,   got.latency_min);
        cmp_field("latency_max",   want.latency_max,   got.latency_max);
        cmp_field("interval_min",  want.interval_min,  got.interval_min);
        cmp_field("interval_max",  want.interval_max,  got.interval_max);
    endtask

    // driver: predicts on acceptance, then offers the next pending word
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_readings.push_back(predict_reading(in_word));
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= (gaps_on && $urandom_range(2) == 0) ? idle_len() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result word
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            check_reading(out_word);
        end
    end

    // output stall generator, with an on-demand long hold
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            stall_left   <= LONG_HOLD - 1;
            out_stall    <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (stall_on && $urandom_range(3) == 0) begin
            stall_left <= idle_len() - 1;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_word(input logic [1:0] op, input logic [63:0] cyc);
        t_in_word w;
        w.op        = op;
        w.cycle_now = cyc;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CYCLE_BASE:       cfg_shadow.cycle_base        = val;
            REG_SYSTEM_TIME_BASE: cfg_shadow.system_time_base  = val;
            REG_SCALE_FRACTION:   cfg_shadow.scale_fraction    = val[31:0];
            REG_SCALE_SHIFT:      cfg_shadow.scale_shift       = val[5:0];
            REG_WALL_SECONDS:     cfg_shadow.wall_seconds_base = val[31:0];
            REG_WALL_NANOS:       cfg_shadow.wall_nanos_base   = val[29:0];
            REG_TICK_PERIOD:      cfg_shadow.tick_period       = val[31:0];
            default: begin
            end
        endcase
    endtask

    task automatic load_setting(input t_cfg s);
        write_reg(REG_CYCLE_BASE,       s.cycle_base);
        write_reg(REG_SYSTEM_TIME_BASE, s.system_time_base);
        write_reg(REG_SCALE_FRACTION,   64'(s.scale_fraction));
        write_reg(REG_SCALE_SHIFT,      64'(s.scale_shift));
        write_reg(REG_WALL_SECONDS,     64'(s.wall_seconds_base));
        write_reg(REG_WALL_NANOS,       64'(s.wall_nanos_base));
        write_reg(REG_TICK_PERIOD,      64'(s.tick_period));
        @(negedge clk);
    endtask

    // wait until every offered word has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_readings.size() != 0) begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    // counter advance between timer events: around one period, some late, some early
    function automatic logic [63:0] event_step(logic [63:0] tick_cyc);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return tick_cyc - tick_cyc / 4 + rand64() % (tick_cyc / 2 + 1);
            5, 6:          return tick_cyc;
            7:             return tick_cyc + 1;
            8:             return tick_cyc * 3;
            default:       return tick_cyc / 3;
        endcase
    endfunction

    // arm-then-events sequences with random reads, plus some raw noise
    task automatic random_traffic(input int count, input logic [63:0] tick_cyc);
        int          made;
        int          burst;
        logic [63:0] cursor;
        made   = 0;
        cursor = rand64();
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                push_word(2'($urandom_range(3)), rand64());
                made++;
            end else begin
                push_word(OP_ARM, cursor);
                made++;
                burst = $urandom_range(3, 10);
                repeat (burst) begin
                    if ($urandom_range(3) == 0) begin
                        push_word(($urandom_range(4) == 0) ? OP_SPARE : OP_READ,
                                  cursor + 64'($urandom_range(1000)));
                        made++;
                    end
                    cursor = cursor + event_step(tick_cyc);
                    push_word(OP_EVENT, cursor);
                    made++;
                end
            end
        end
    endtask

    // stimulus sequence
    initial begin
        t_cfg        s;
        logic [63:0] c0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: zero fraction, every time reads as zero
        push_word(OP_READ,  64'd0);
        push_word(OP_READ,  '1);
        push_word(OP_SPARE, '1);
        push_word(OP_ARM,   64'h5555_5555_5555_5555);
        push_word(OP_EVENT, 64'hAAAA_AAAA_AAAA_AAAA);
        push_word(OP_EVENT, 64'd0);
        random_traffic(30, 64'd1);
        wait_drained();

        // one ns per cycle, sub-second wall nanos at the top of its range
        s = '{64'h1000, 64'd5_000_000_000, 32'h8000_0000, 6'd1,
              32'd1_700_000_000, 30'd999_999_999, 32'd1000};
        load_setting(s);
        c0 = 64'h1000 + 64'd10_000;
        push_word(OP_ARM,   c0);
        push_word(OP_EVENT, c0 + 64'd1000);
        push_word(OP_EVENT, c0 + 64'd2001);
        push_word(OP_EVENT, c0 + 64'd503_000);
        push_word(OP_EVENT, c0 + 64'd4000);
        push_word(OP_EVENT, c0 + 64'd4500);
        push_word(OP_READ,  64'd0);
        push_word(OP_SPARE, c0);
        // long output hold with the sender offering back to back
        gaps_on = 1'b0;
        hold_requests++;
        random_traffic(100, 64'd1000);
        wait_drained();
        gaps_on = 1'b1;
        random_traffic(40, 64'd1000);
        wait_drained();

        // small right shift, system time near the wrap, oversized wall nanos
        s = '{rand64(), 64'hFFFF_FFFF_FFF0_0000, 32'hFFFF_FFFF, 6'h3E,
              $urandom, 30'h3FFF_FFFF, 32'd5000};
        load_setting(s);
        random_traffic(60, 64'd20_000);
        wait_drained();

        // every register at its top value, largest left shift, zero period
        s = '{'1, '1, 32'hFFFF_FFFF, 6'h1F, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 32'd0};
        load_setting(s);
        push_word(OP_READ,  '1);
        push_word(OP_READ,  64'd0);
        push_word(OP_ARM,   '1);
        push_word(OP_EVENT, 64'd0);
        push_word(OP_EVENT, 64'd1);
        random_traffic(50, 64'd1);
        wait_drained();

        // widest right shift, no idling on either side
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        s = '{64'd0, 64'd0, 32'hFFFF_FFFF, 6'h20, 32'd0, 30'd0, 32'd3};
        load_setting(s);
        random_traffic(50, 64'h3_0000_0000);
        wait_drained();
        gaps_on  = 1'b1;
        stall_on = 1'b1;

        // largest period
        s = '{rand64(), rand64(), 32'h8000_0000, 6'd1, $urandom, 30'd0, 32'hFFFF_FFFF};
        load_setting(s);
        random_traffic(50, 64'hFFFF_FFFF);
        wait_drained();

        // shift of minus one, quarter fraction
        s = '{rand64(), rand64(), 32'h4000_0000, 6'h3F, $urandom, 30'd500_000_000, 32'd100};
        load_setting(s);
        random_traffic(40, 64'd800);
        wait_drained();

        // shift of minus thirty-one
        s = '{rand64(), rand64(), 32'hFFFF_FFFF, 6'h21, $urandom, 30'($urandom), 32'd7};
        load_setting(s);
        random_traffic(40, 64'd7 << 31);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0) begin
            $display("[paravirt_clock_and_tick_stats] OK");
        end else begin
            $display("[paravirt_clock_and_tick_stats] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("[paravirt_clock_and_tick_stats] ERROR");
        $finish;
    end

endmodule

### files.f
hdl/pvclk_pkg.sv
hdl/pvclk_scale.sv
hdl/pvclk_wall.sv
hdl/pvclk_stats.sv
hdl/paravirt_clock_and_tick_stats.sv
verif/testbench.sv
